### src/fteq_pkg.sv
package fteq_pkg;

    localparam int TIME_W  = 48;
    localparam int LIMIT_W = 16;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 6;
    localparam int TICK_CAP = 32;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_HIT    = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [1:0] RES_NONE     = 2'd0;
    localparam logic [1:0] RES_HARD_DEL = 2'd1;
    localparam logic [1:0] RES_IDLE_DEL = 2'd2;
    localparam logic [1:0] RES_IDLE_REP = 2'd3;

    // one flow entry as stored in the slot memory
    typedef struct packed {
        logic [LIMIT_W-1:0] hard_lim;
        logic [LIMIT_W-1:0] idle_lim;
        logic [TIME_W-1:0]  ins_time;
        logic [TIME_W-1:0]  act_time;
        logic               notify;
        logic [STAMP_W-1:0] stamp;
    } flow_ent_t;

    // per-entry deadline, 0 limit gives no deadline
    typedef struct packed {
        logic              due;
        logic              hard;
        logic [TIME_W:0]   exp;
    } exp_info_t;

endpackage

### src/fteq_deadline.sv
// Two-stage deadline calc: limit * ms multiply registered, then add and compare.
module fteq_deadline
    import fteq_pkg::*;
#(
    parameter int MS_PER_SECOND = 1000
)(
    input  logic              clk,
    input  logic [LIMIT_W-1:0] hard_lim,
    input  logic [LIMIT_W-1:0] idle_lim,
    input  logic [TIME_W-1:0]  ins_time,
    input  logic [TIME_W-1:0]  act_time,
    input  logic [TIME_W-1:0]  now_ms,
    output exp_info_t          info
);
    localparam int MS_W = $clog2(MS_PER_SECOND + 1);
    localparam logic [MS_W-1:0] MS_K = MS_W'(MS_PER_SECOND);

    logic [LIMIT_W+MS_W-1:0] hard_ms_reg, idle_ms_reg;
    logic                    hard_en_reg, idle_en_reg;
    logic [TIME_W-1:0]       ins_reg, act_reg;

    always_ff @(posedge clk)
    begin
        hard_ms_reg <= hard_lim * MS_K;
        idle_ms_reg <= idle_lim * MS_K;
        hard_en_reg <= (hard_lim != '0);
        idle_en_reg <= (idle_lim != '0);
        ins_reg     <= ins_time;
        act_reg     <= act_time;
    end

    logic [TIME_W+1:0] h_dl, i_dl;
    always_comb
    begin
        h_dl = {2'b00, ins_reg} + (TIME_W+2)'(hard_ms_reg);
        i_dl = {2'b00, act_reg} + (TIME_W+2)'(idle_ms_reg);
        if (!hard_en_reg)
            h_dl = '1;
        if (!idle_en_reg)
            i_dl = '1;
        info.hard = (h_dl <= i_dl);
        info.exp  = info.hard ? h_dl[TIME_W:0] : i_dl[TIME_W:0];
        if (info.hard ? h_dl[TIME_W+1] : i_dl[TIME_W+1])
            info.exp = '1;
        info.due = (hard_en_reg || idle_en_reg) && !(info.hard ? h_dl[TIME_W+1] : i_dl[TIME_W+1])
                   && (info.exp <= {1'b0, now_ms});
    end
endmodule

### src/flow_timeout_expiry_queue.sv
// Flow timeout expiry queue.
// Channels: start/busy command input (req_type, slot, limits, notify_idle, now_ms),
// result words out on event_res/event_slot/last marked by done for one cycle;
// the receiver cannot stall. Config: cfg_we/cfg_wdata writes max_per_tick.
// One request at a time. Add, remove, hit: one result word, sent from ST_ACT after start.
// Tick: repeated scans of the slot memory; each scan reads every slot once
// through the registered memory port and a two-stage deadline pipe, then
// ST_RD, ST_WAIT and ST_ACT read-modify-write the selected entry.
// A tick costs events+hits+1 scans (none if max_per_tick is 0), one fewer at the cap;
// the final word at the cap goes out via ST_WAIT and ST_ACT after the last handled flow.
// Each event word is held until a later scan (or the cap) shows whether it is
// the final one; last marks it, and a tick with no event gives one word {0,0,1}.
// Reset: valid and hit bits (flip-flops) and stamp counter clear, max_per_tick
// returns to 32; the entry memory is not cleared and needs no sweep.
// busy drops at the edge that puts the last word of the request out.
module flow_timeout_expiry_queue
    import fteq_pkg::*;
#(
    parameter int NUM_SLOTS     = 256,
    parameter int MS_PER_SECOND = 1000
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [7:0]         slot,
    input  logic [LIMIT_W-1:0] hard_limit_s,
    input  logic [LIMIT_W-1:0] idle_limit_s,
    input  logic               notify_idle,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    output logic               done,
    output logic [1:0]         event_res,
    output logic [7:0]         event_slot,
    output logic               last
);
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int CW = AW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_ACT  = 3'd4;

    // entry memory, registered synchronous read
    flow_ent_t mem [NUM_SLOTS];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    flow_ent_t       mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    logic [NUM_SLOTS-1:0] valid_reg, hit_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [CFG_W-1:0]     max_reg;
    logic [2:0]           state_reg;
    logic [CW-1:0]        scan_reg;      // read address counter
    logic [AW-1:0]        p1_reg, p2_reg;  // slot tags in pipe
    logic                 v1_reg, v2_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [1:0]           req_reg;
    logic [7:0]           slot_reg;
    logic [5:0]           cnt_reg;
    logic                 found_reg, best_hard_reg;
    logic [AW-1:0]        best_reg;
    logic [TIME_W:0]      best_exp_reg;
    logic [STAMP_W-1:0]   best_age_reg;
    logic                 pend_reg;      // event word held until a later scan ends
    logic [1:0]           pend_res_reg;
    logic [7:0]           pend_slot_reg;
    logic                 done_reg, last_reg;
    logic [1:0]           res_reg;
    logic [7:0]           oslot_reg;
    logic                 fin_cap_reg;   // final word after cap uses the held event code

    logic [STAMP_W-1:0] stamp_d1_reg;
    exp_info_t          info;

    fteq_deadline #(.MS_PER_SECOND(MS_PER_SECOND)) u_dl (
        .clk      (clk),
        .hard_lim (mem_rdata.hard_lim),
        .idle_lim (mem_rdata.idle_lim),
        .ins_time (mem_rdata.ins_time),
        .act_time (mem_rdata.act_time),
        .now_ms   (now_reg),
        .info     (info)
    );

    always_ff @(posedge clk)
        stamp_d1_reg <= mem_rdata.stamp;

    logic [STAMP_W-1:0] age;
    logic               cand, better;
    logic [5:0]         lim;
    always_comb
    begin
        age    = stamp_reg - stamp_d1_reg;
        cand   = v2_reg && valid_reg[p2_reg] && info.due;
        better = !found_reg || (info.exp < best_exp_reg)
                 || (info.exp == best_exp_reg && age > best_age_reg);
        lim    = (max_reg > CFG_W'(TICK_CAP)) ? 6'(TICK_CAP) : max_reg;
    end

    always_comb
    begin
        mem_raddr = (state_reg == ST_SCAN) ? scan_reg[AW-1:0] : best_reg;
        mem_we    = 1'b0;
        mem_waddr = best_reg;
        mem_wdata = mem_rdata;
        if (start && !busy && req_type == REQ_ADD
            && {{(32-8){1'b0}}, slot} < 32'(NUM_SLOTS))
        begin
            mem_we             = 1'b1;
            mem_waddr          = slot[AW-1:0];
            mem_wdata.hard_lim = hard_limit_s;
            mem_wdata.idle_lim = idle_limit_s;
            mem_wdata.ins_time = now_ms;
            mem_wdata.act_time = now_ms;
            mem_wdata.notify   = notify_idle;
            mem_wdata.stamp    = stamp_reg;
        end
        else if (state_reg == ST_ACT && req_reg == REQ_TICK && lim != '0
                 && !best_hard_reg && (hit_reg[best_reg] || mem_rdata.notify))
        begin
            mem_we             = 1'b1;
            mem_wdata.act_time = now_reg;
            mem_wdata.stamp    = stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            hit_reg     <= '0;
            stamp_reg   <= '0;
            max_reg     <= CFG_W'(TICK_CAP);
            state_reg   <= ST_IDLE;
            busy        <= 1'b0;
            done_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            found_reg   <= 1'b0;
            scan_reg    <= '0;
            cnt_reg     <= '0;
            fin_cap_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                max_reg <= cfg_wdata;
            v1_reg <= (state_reg == ST_SCAN) && (scan_reg < CW'(NUM_SLOTS));
            v2_reg <= v1_reg;
            p1_reg <= scan_reg[AW-1:0];
            p2_reg <= p1_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        busy     <= 1'b1;
                        req_reg  <= req_type;
                        slot_reg <= slot;
                        now_reg  <= now_ms;
                        if (req_type == REQ_TICK)
                        begin
                            cnt_reg <= '0;
                            pend_reg <= 1'b0;
                            if (((max_reg > CFG_W'(TICK_CAP)) ? 6'(TICK_CAP) : max_reg) == '0)
                                state_reg <= ST_ACT;
                            else
                            begin
                                state_reg <= ST_SCAN;
                                scan_reg  <= '0;
                                found_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_ACT;
                            if ({{(32-8){1'b0}}, slot} < 32'(NUM_SLOTS))
                            begin
                                if (req_type == REQ_ADD)
                                begin
                                    valid_reg[slot[AW-1:0]] <= 1'b1;
                                    hit_reg[slot[AW-1:0]]   <= 1'b0;
                                    stamp_reg <= stamp_reg + 1'b1;
                                end
                                else if (req_type == REQ_REMOVE)
                                begin
                                    valid_reg[slot[AW-1:0]] <= 1'b0;
                                    hit_reg[slot[AW-1:0]]   <= 1'b0;
                                end
                                else if (valid_reg[slot[AW-1:0]])
                                    hit_reg[slot[AW-1:0]] <= 1'b1;
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_reg < CW'(NUM_SLOTS + 3))
                        scan_reg <= scan_reg + 1'b1;
                    if (cand && better)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= p2_reg;
                        best_exp_reg  <= info.exp;
                        best_age_reg  <= age;
                        best_hard_reg <= info.hard;
                    end
                    if (scan_reg == CW'(NUM_SLOTS + 3))
                    begin
                        if (!found_reg && !cand)
                        begin
                            // nothing due: close the tick
                            done_reg  <= 1'b1;
                            last_reg  <= 1'b1;
                            res_reg   <= pend_reg ? pend_res_reg : RES_NONE;
                            oslot_reg <= pend_reg ? pend_slot_reg : 8'd0;
                            busy      <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_RD;
                    end
                end
                ST_RD:
                    state_reg <= ST_WAIT;  // memory read of best
                ST_WAIT:
                    state_reg <= ST_ACT;
                default:   // ST_ACT
                begin
                    if (req_reg != REQ_TICK || lim == '0)
                    begin
                        done_reg    <= 1'b1;
                        last_reg    <= 1'b1;
                        res_reg     <= fin_cap_reg ? pend_res_reg : RES_NONE;
                        oslot_reg   <= (req_reg == REQ_TICK) ? 8'd0 : slot_reg;
                        fin_cap_reg <= 1'b0;
                        busy        <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        logic       ev;
                        logic [1:0] r;
                        ev = 1'b1;
                        r  = RES_HARD_DEL;
                        if (best_hard_reg)
                        begin
                            valid_reg[best_reg] <= 1'b0;
                            hit_reg[best_reg]   <= 1'b0;
                        end
                        else
                        begin
                            hit_reg[best_reg] <= 1'b0;
                            if (hit_reg[best_reg] || mem_rdata.notify)
                                stamp_reg <= stamp_reg + 1'b1;
                            if (hit_reg[best_reg])
                                ev = 1'b0;
                            else if (mem_rdata.notify)
                                r = RES_IDLE_REP;
                            else
                            begin
                                r = RES_IDLE_DEL;
                                valid_reg[best_reg] <= 1'b0;
                            end
                        end
                        found_reg <= 1'b0;
                        scan_reg  <= '0;
                        if (ev)
                        begin
                            if (pend_reg)
                            begin
                                done_reg  <= 1'b1;
                                last_reg  <= 1'b0;
                                res_reg   <= pend_res_reg;
                                oslot_reg <= pend_slot_reg;
                            end
                            pend_res_reg  <= r;
                            pend_slot_reg <= 8'(best_reg);
                            cnt_reg       <= cnt_reg + 1'b1;
                            if (cnt_reg + 1'b1 >= lim)
                            begin
                                // cap reached: finish with the held word
                                pend_reg    <= 1'b0;
                                fin_cap_reg <= 1'b1;
                                state_reg   <= ST_WAIT;
                                req_reg     <= REQ_ADD;
                                slot_reg    <= 8'(best_reg);
                            end
                            else
                            begin
                                pend_reg  <= 1'b1;
                                state_reg <= ST_SCAN;
                            end
                        end
                        else
                            state_reg <= ST_SCAN;
                    end
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign event_res  = res_reg;
    assign event_slot = oslot_reg;
    assign last       = last_reg;
endmodule

### src/fteq_checker.sv
module fteq_port_checker
    import fteq_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] req_type,
    input logic       done,
    input logic [1:0] event_res,
    input logic [7:0] event_slot,
    input logic       last
);
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |-> $fell(busy)) else $error("busy not dropped with last");
    a_nodone_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !done) else $error("word while idle");
    a_ack: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type != REQ_TICK |=> ##1 done && last && event_res == RES_NONE)
        else $error("ack missing");
endmodule

bind flow_timeout_expiry_queue fteq_port_checker u_fteq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req_type(req_type),
    .done(done), .event_res(event_res), .event_slot(event_slot), .last(last)
);

### bench/fteq_checker.sv
`timescale 1ns / 100ps

// Watches the request, config and result ports of the flow timeout queue,
// keeps its own copy of the flow table and compares every result word.
module fteq_checker
    import fteq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         req_type,
    input  logic [7:0]         slot,
    input  logic [LIMIT_W-1:0] hard_limit_s,
    input  logic [LIMIT_W-1:0] idle_limit_s,
    input  logic               notify_idle,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               done,
    input  logic [1:0]         event_res,
    input  logic [7:0]         event_slot,
    input  logic               last,
    output int                 fail_count,
    output int                 words_due,
    output int                 event_count
);

    localparam int SLOTS = 256;
    localparam logic [63:0] NO_DEADLINE = '1;

    typedef struct packed {
        logic [1:0] res;
        logic [7:0] slot;
        logic       last;
    } event_word_t;

    event_word_t expected_words[$];

    logic                live      [SLOTS];
    logic                was_hit   [SLOTS];
    logic                notify_on [SLOTS];
    logic [LIMIT_W-1:0]  hard_s    [SLOTS];
    logic [LIMIT_W-1:0]  idle_s    [SLOTS];
    logic [TIME_W-1:0]   added_at  [SLOTS];
    logic [TIME_W-1:0]  active_at  [SLOTS];
    logic [STAMP_W-1:0]  queue_pos [SLOTS];
    logic [STAMP_W-1:0]  next_pos;
    logic [CFG_W-1:0]    tick_budget;

    function automatic logic [63:0] deadline(int s, output logic is_hard);
        logic [63:0] h;
        logic [63:0] i;
        h = NO_DEADLINE;
        i = NO_DEADLINE;
        if (hard_s[s] != 0) h = 64'(added_at[s]) + 64'(hard_s[s]) * 64'd1000;
        if (idle_s[s] != 0) i = 64'(active_at[s]) + 64'(idle_s[s]) * 64'd1000;
        is_hard = (h <= i);
        return is_hard ? h : i;
    endfunction

    task automatic requeue(int s);
        queue_pos[s] = next_pos;
        next_pos     = next_pos + 1;
    endtask

    // expiry walk of one tick: earliest due flow first, oldest queue position on ties
    task automatic run_tick(logic [TIME_W-1:0] now);
        int          cap;
        int          n;
        int          best;
        logic        found;
        logic        best_hard;
        logic        hard;
        logic [63:0] best_exp;
        logic [63:0] e;
        logic [31:0] best_age;
        logic [31:0] age;
        logic        hit;
        event_word_t w;
        cap = (tick_budget > TICK_CAP) ? TICK_CAP : int'(tick_budget);
        n = 0;
        while (n < cap) begin
            found = 0;
            best = 0;
            best_hard = 0;
            best_exp = NO_DEADLINE;
            best_age = 0;
            for (int s = 0; s < SLOTS; s++) begin
                if (!live[s]) continue;
                e = deadline(s, hard);
                if (e == NO_DEADLINE || e > 64'(now)) continue;
                age = next_pos - queue_pos[s];
                if (!found || e < best_exp || (e == best_exp && age > best_age)) begin
                    found = 1;
                    best = s;
                    best_exp = e;
                    best_age = age;
                    best_hard = hard;
                end
            end
            if (!found) break;
            if (best_hard) begin
                live[best] = 0;
                was_hit[best] = 0;
                w = '{RES_HARD_DEL, 8'(best), 1'b0};
                expected_words.push_back(w);
                n++;
            end else begin
                hit = was_hit[best];
                was_hit[best] = 0;
                if (hit || notify_on[best]) begin
                    active_at[best] = now;
                    requeue(best);
                end
                if (!hit) begin
                    if (notify_on[best]) begin
                        w = '{RES_IDLE_REP, 8'(best), 1'b0};
                    end else begin
                        live[best] = 0;
                        w = '{RES_IDLE_DEL, 8'(best), 1'b0};
                    end
                    expected_words.push_back(w);
                    n++;
                end
            end
        end
        if (n == 0) begin
            w = '{RES_NONE, 8'd0, 1'b1};
            expected_words.push_back(w);
        end else begin
            expected_words[$].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        event_word_t got;
        event_word_t want;
        if (!rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                live[s] = 0;
                was_hit[s] = 0;
            end
            next_pos = 0;
            tick_budget = 6'd32;
            expected_words.delete();
            fail_count = 0;
            event_count = 0;
            words_due = 0;
        end else begin
            // results first: a word can leave at the same edge a new request lands
            if (done) begin
                got = '{event_res, event_slot, last};
                if (got.res != RES_NONE) event_count++;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected word res=%0d slot=%0d last=%0b",
                                 $realtime, got.res, got.slot, got.last);
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: word mismatch exp res=%0d slot=%0d last=%0b, got res=%0d slot=%0d last=%0b",
                                     $realtime, want.res, want.slot, want.last,
                                     got.res, got.slot, got.last);
                    end
                end
            end
            if (cfg_we) tick_budget = cfg_wdata;
            if (start && !busy) begin
                if (req_type == REQ_TICK) begin
                    run_tick(now_ms);
                end else begin
                    case (req_type)
                        REQ_ADD: begin
                            live[slot] = 1;
                            hard_s[slot] = hard_limit_s;
                            idle_s[slot] = idle_limit_s;
                            notify_on[slot] = notify_idle;
                            added_at[slot] = now_ms;
                            active_at[slot] = now_ms;
                            was_hit[slot] = 0;
                            requeue(slot);
                        end
                        REQ_REMOVE: begin
                            live[slot] = 0;
                            was_hit[slot] = 0;
                        end
                        default: if (live[slot]) was_hit[slot] = 1;
                    endcase
                    expected_words.push_back('{RES_NONE, slot, 1'b1});
                end
            end
            words_due = expected_words.size();
        end
    end

endmodule

### bench/tb_flow_timeout_expiry_queue.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the flow timeout queue; fteq_checker checks the words.
module tb_flow_timeout_expiry_queue;
    import fteq_pkg::*;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic [7:0]         slot;
    logic [LIMIT_W-1:0] hard_limit_s;
    logic [LIMIT_W-1:0] idle_limit_s;
    logic               notify_idle;
    logic [TIME_W-1:0]  now_ms;
    logic               cfg_we;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               done;
    logic [1:0]         event_res;
    logic [7:0]         event_slot;
    logic               last;

    int fail_count;
    int words_due;
    int event_count;
    int words_sent;
    int ticks_sent;
    logic idle_gaps_on;       // random bubbles between request words
    logic [TIME_W-1:0] wall_ms;  // running "current time" for the random part

    flow_timeout_expiry_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .slot        (slot),
        .hard_limit_s(hard_limit_s),
        .idle_limit_s(idle_limit_s),
        .notify_idle (notify_idle),
        .now_ms      (now_ms),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .event_res   (event_res),
        .event_slot  (event_slot),
        .last        (last)
    );

    fteq_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .slot        (slot),
        .hard_limit_s(hard_limit_s),
        .idle_limit_s(idle_limit_s),
        .notify_idle (notify_idle),
        .now_ms      (now_ms),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .event_res   (event_res),
        .event_slot  (event_slot),
        .last        (last),
        .fail_count  (fail_count),
        .words_due   (words_due),
        .event_count (event_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Present one request word at a falling edge and hold it until accepted.
    // start is left high; the next call or settle() replaces or drops it.
    task automatic issue(logic [1:0] kind, logic [7:0] s, logic [15:0] hs,
                         logic [15:0] is, logic nt, logic [TIME_W-1:0] t);
        @(negedge clk);
        if (idle_gaps_on && $urandom_range(0, 99) < 6) begin
            start = 1'b0;
            @(negedge clk);
        end
        req_type = kind;
        slot = s;
        hard_limit_s = hs;
        idle_limit_s = is;
        notify_idle = nt;
        now_ms = t;
        start = 1'b1;
        do @(posedge clk); while (busy);
        words_sent++;
        if (kind == REQ_TICK) ticks_sent++;
    endtask

    // Drop start and wait until every expected word has come out and the block is quiet.
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        do @(posedge clk); while (words_due != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_budget(logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One random request: mostly adds and ticks on a small slot pool so flows collide
    // and expire; now and then full-range slots, limits and times for bit coverage.
    task automatic random_word();
        int pick;
        logic [7:0] s;
        logic [15:0] hs;
        logic [15:0] is;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(0, 99);
        s = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        hs = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        is = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        wall_ms = wall_ms + $urandom_range(0, 1500);
        t = ($urandom_range(0, 24) == 0) ? {16'($urandom), 32'($urandom)} : wall_ms;
        if (pick < 40)
            issue(REQ_ADD, s, hs, is, 1'($urandom), t);
        else if (pick < 58)
            issue(REQ_HIT, s, 16'($urandom), 16'($urandom), 1'($urandom), t);
        else if (pick < 68)
            issue(REQ_REMOVE, s, 16'($urandom), 16'($urandom), 1'($urandom), t);
        else
            issue(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), t);
    endtask

    initial begin
        logic [CFG_W-1:0] budgets[6];
        budgets = '{6'd1, 6'd63, 6'd0, 6'd2, 6'd32, 6'd5};
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ADD;
        slot = '0;
        hard_limit_s = '0;
        idle_limit_s = '0;
        notify_idle = 1'b0;
        now_ms = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        words_sent = 0;
        ticks_sent = 0;
        idle_gaps_on = 1'b0;
        wall_ms = 48'd10000;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: budget at its reset value of 32
        issue(REQ_ADD, 8'd0, 16'd1, 16'd0, 1'b0, 48'd1000);       // hard deadline 2000
        issue(REQ_ADD, 8'd255, 16'd0, 16'd1, 1'b1, 48'd1000);     // idle with report
        issue(REQ_ADD, 8'd1, 16'd0, 16'd1, 1'b0, 48'd1000);       // idle with delete
        issue(REQ_ADD, 8'd2, 16'd2, 16'd2, 1'b0, 48'd1000);       // hard/idle tie counts as hard
        issue(REQ_ADD, 8'd3, 16'd0, 16'd0, 1'b0, 48'd1000);       // never expires
        issue(REQ_ADD, 8'd4, 16'hFFFF, 16'hFFFF, 1'b1, TIME_MAX); // deadline past time range
        issue(REQ_HIT, 8'd1, 16'd0, 16'd0, 1'b0, 48'd1000);       // hit keeps the idle flow
        issue(REQ_HIT, 8'd100, 16'd0, 16'd0, 1'b0, 48'd0);        // hit on empty slot
        issue(REQ_REMOVE, 8'd101, 16'd0, 16'd0, 1'b0, 48'd0);     // remove on empty slot
        issue(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 48'd999);       // nothing due yet
        issue(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 48'd2000);
        issue(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 48'd3000);
        issue(REQ_ADD, 8'd3, 16'd1, 16'd0, 1'b1, 48'd3000);       // overwrite an occupied slot
        issue(REQ_REMOVE, 8'd255, 16'd0, 16'd0, 1'b0, 48'd3000);
        issue(REQ_ADD, 8'd5, 16'hFFFF, 16'd0, 1'b0, 48'd0);
        issue(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0, 48'd65535000);
        issue(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0, TIME_MAX);
        settle();

        // random phases, each under its own per-tick budget
        for (int ph = 0; ph < 6; ph++) begin
            write_budget(budgets[ph]);
            idle_gaps_on = (ph != 4);  // one long stretch with back-to-back words
            for (int k = 0; k < 60; k++) random_word();
            settle();
        end

        $display("Sent %0d request words (%0d ticks) over 7 budget settings,",
                 words_sent, ticks_sent);
        $display("saw %0d expiry events; failures: %0d", event_count, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Timed out with %0d words still due", words_due);
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/fteq_pkg.sv
src/fteq_deadline.sv
src/flow_timeout_expiry_queue.sv
src/fteq_checker.sv
bench/fteq_checker.sv
bench/tb_flow_timeout_expiry_queue.sv
